// File: hdl/adagrad_parameter_update_assert.svh
// Assertion macros used by the port-level checker file.
`ifndef ADAGRAD_PARAMETER_UPDATE_ASSERT_SVH
`define ADAGRAD_PARAMETER_UPDATE_ASSERT_SVH
// A condition implies a consequence at the same edge.
`define AGU_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);
// A condition implies a consequence at the next edge.
`define AGU_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);
`endif

// File: hdl/agu_pkg.sv
// ----------------------------------------------------------------------------
// AdaGrad update package
// Shared widths, register indexes and types.
// ----------------------------------------------------------------------------
package agu_pkg;
	localparam int NumElements = 4096;
	localparam int IdxW = 12;
	localparam int DataW = 32;
	localparam int AccW = 64;
	localparam logic [0:0] RegLearningRate = 1'b0;
	localparam logic [0:0] RegEpsilon = 1'b1;

	// Request to the divider and its answer.
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;
endpackage

// File: hdl/agu_divider.sv
// ----------------------------------------------------------------------------
// AdaGrad update divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module agu_divider import agu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [33:0] diff;

	always_comb begin
		trial = {rem_q[31:0], quo_q[63]};
		diff = {1'b0, trial} - {2'b00, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			rsp.done <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					rsp.done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.quotient = quo_q;
endmodule

// File: hdl/adagrad_parameter_update.sv
// ----------------------------------------------------------------------------
// AdaGrad parameter update
// Per-element squared-gradient accumulator in a synchronous memory, integer
// square root and step division, saturating parameter update.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// in        input      in_valid / in_stall
// out       output     out_valid / out_stall
// cfg       input      cfg_we, cfg_index, cfg_data
//
// After its word is accepted, the memory is read and the gradient squared,
// the root loop runs (a load and 32 iterations), the divider is started and
// runs its 64 iterations up to its done flag, and the result is registered.
// The block takes no new word until it is through with the previous one.
// After reset a clearing pass writes zero to all 4096 accumulator
// entries while no word is accepted.
// A stalled result holds in the output register; the next word is accepted
// only once the result has gone.
// ----------------------------------------------------------------------------
module adagrad_parameter_update import agu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [IdxW-1:0]    element_index,
	input  logic signed [31:0] param_value,
	input  logic signed [31:0] gradient,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IdxW-1:0]    result_index,
	output logic signed [31:0] new_param,
	output logic               saturated
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_MUL, ST_ACC, ST_ROOT, ST_DIVSTART, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;
	logic [AccW-1:0] mem [NumElements];
	logic [AccW-1:0] rd_data;
	logic [IdxW-1:0] clr_q;
	logic [31:0] lr_q, eps_q;
	logic [IdxW-1:0] idx_q;
	logic signed [31:0] p_q;
	logic gneg_q;
	logic [31:0] gmag_q;
	logic [63:0] sq_q, acc_q, n_q, res_q, bit_q, num_q;
	logic sat_q;
	logic [5:0] it_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic we;
	logic [IdxW-1:0] waddr;
	logic [AccW-1:0] wdata;
	logic [64:0] acc_sum, eps_sum;
	logic [64:0] rb;
	logic [63:0] step;
	logic signed [34:0] np;
	logic [31:0] gin_mag;

	agu_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_stall = (state_q != ST_IDLE);
	assign gin_mag = gradient[31] ? (~gradient + 32'd1) : gradient;
	assign acc_sum = {1'b0, rd_data} + {1'b0, sq_q};
	assign eps_sum = {1'b0, acc_q} + {33'd0, eps_q};
	assign rb = {1'b0, res_q} + {1'b0, bit_q};
	assign step = (drsp.quotient > 64'h2_0000_0000) ? 64'h2_0000_0000 : drsp.quotient;
	assign np = gneg_q ? ({{3{p_q[31]}}, p_q} + $signed({1'b0, step[33:0]}))
	                   : ({{3{p_q[31]}}, p_q} - $signed({1'b0, step[33:0]}));

	// A zero root gives a zero step: divide zero by one.
	assign dreq.start = (state_q == ST_DIVSTART);
	assign dreq.dividend = (res_q == '0) ? '0 : num_q;
	assign dreq.divisor = (res_q == '0) ? 32'd1 : res_q[31:0];

	always_comb begin
		we = 1'b0;
		waddr = clr_q;
		wdata = '0;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
		end else if (state_q == ST_ACC) begin
			we = 1'b1;
			waddr = idx_q;
			wdata = acc_sum[64] ? '1 : acc_sum[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			lr_q <= 32'd655;
			eps_q <= 32'd43;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == RegLearningRate) begin
					lr_q <= cfg_data;
				end else begin
					eps_q <= cfg_data;
				end
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IdxW'(NumElements - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						idx_q <= element_index;
						p_q <= param_value;
						gneg_q <= gradient[31];
						gmag_q <= gin_mag;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					sq_q <= 64'(gmag_q) * 64'(gmag_q);
					num_q <= 64'(lr_q) * 64'(gmag_q);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sat_q <= acc_sum[64];
					acc_q <= acc_sum[64] ? '1 : acc_sum[63:0];
					state_q <= ST_ROOT;
					it_q <= '0;
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
				end
				ST_ROOT: begin
					// First pass loads the radicand; the next 32 run the root.
					if (it_q == 6'd0) begin
						n_q <= eps_sum[64] ? '1 : eps_sum[63:0];
						it_q <= 6'd1;
					end else begin
						if ({1'b0, n_q} >= rb) begin
							n_q <= n_q - rb[63:0];
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
						it_q <= it_q + 6'd1;
						if (it_q == 6'd32) state_q <= ST_DIVSTART;
					end
				end
				ST_DIVSTART: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (drsp.done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid) begin
						result_index <= idx_q;
						if (np > 35'sh0_7FFF_FFFF) begin
							new_param <= 32'sh7FFF_FFFF;
							saturated <= 1'b1;
						end else if (np < -35'sh0_8000_0000) begin
							new_param <= 32'sh8000_0000;
							saturated <= 1'b1;
						end else begin
							new_param <= np[31:0];
							saturated <= sat_q;
						end
						out_valid <= 1'b1;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/agu_checker.sv
// ----------------------------------------------------------------------------
// AdaGrad update checker
// Port-level properties of the update block.
// ----------------------------------------------------------------------------
`include "adagrad_parameter_update_assert.svh"
module agu_checker import agu_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input logic [IdxW-1:0] result_index,
	input logic            saturated
);
	`AGU_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_index) && $stable(saturated), "stalled result changed")
	`AGU_ASSERT_IMP(a_busy, clk, arst_n, out_valid, in_stall, "word accepted while result pending")
	`AGU_ASSERT_NEXT(a_one, clk, arst_n, in_valid && !in_stall, in_stall && !out_valid, "accept did not start work")
endmodule

bind adagrad_parameter_update agu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .result_index(result_index),
	.saturated(saturated)
);

// File: sim/adagrad_parameter_update_checker.sv
// ----------------------------------------------------------------------------
// AdaGrad update checker
// Watches the configuration port and both channels, keeps its own copy of the
// accumulators and registers, predicts each result and compares it in order.
// ----------------------------------------------------------------------------
module adagrad_parameter_update_checker import agu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [IdxW-1:0]    element_index,
	input  logic signed [31:0] param_value,
	input  logic signed [31:0] gradient,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [IdxW-1:0]    result_index,
	input  logic signed [31:0] new_param,
	input  logic               saturated,
	output int                 fail_count,
	output int                 pending
);
	typedef struct packed {
		logic [IdxW-1:0] idx;
		logic [31:0]     value;
		logic            sat;
	} update_t;

	logic [63:0] sum_mem [NumElements];
	logic [31:0] alpha;
	logic [31:0] eps;
	update_t     expected_updates [$];

	assign pending = expected_updates.size();

	function automatic logic [63:0] floor_root(logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Works out one update and advances the accumulator of that element.
	function automatic update_t predict_update(logic [IdxW-1:0] idx, logic [31:0] p,
			logic [31:0] g);
		update_t u;
		logic        neg;
		logic [63:0] mag;
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] s;
		logic [63:0] d;
		logic [63:0] st;
		longint      np;
		neg = g[31];
		mag = neg ? {32'd0, -g} : {32'd0, g};
		acc = (idx < NumElements) ? sum_mem[idx] : 64'd0;
		sq = mag * mag;
		u.sat = 1'b0;
		if (acc > ~sq) begin
			acc = '1;
			u.sat = 1'b1;
		end else begin
			acc = acc + sq;
		end
		if (idx < NumElements) sum_mem[idx] = acc;
		s = (acc > ~{32'd0, eps}) ? '1 : acc + eps;
		d = floor_root(s);
		if (d == 0) begin
			st = 0;
		end else begin
			st = ({32'd0, alpha} * mag) / d;
			if (st > (64'd1 << 33)) st = 64'd1 << 33;
		end
		np = neg ? longint'(signed'(p)) + longint'(st) : longint'(signed'(p)) - longint'(st);
		if (np > 64'sh7FFFFFFF) begin
			np = 64'sh7FFFFFFF;
			u.sat = 1'b1;
		end else if (np < -64'sh80000000) begin
			np = -64'sh80000000;
			u.sat = 1'b1;
		end
		u.idx = idx;
		u.value = np[31:0];
		return u;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		update_t e;
		if (!arst_n) begin
			for (int k = 0; k < NumElements; k++) sum_mem[k] = 64'd0;
			alpha <= 32'd655;
			eps <= 32'd43;
			fail_count <= 0;
			expected_updates.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == RegLearningRate) alpha <= cfg_data;
				else eps <= cfg_data;
			end
			if (in_valid && !in_stall)
				expected_updates.push_back(predict_update(element_index, param_value,
					gradient));
			if (out_valid && !out_stall) begin
				if (expected_updates.size() == 0) begin
					if (fail_count < 10) $display("unexpected word: idx %0d", result_index);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_updates.pop_front();
					if (e.idx !== result_index || e.value !== new_param ||
							e.sat !== saturated) begin
						if (fail_count < 10)
							$display("mismatch: exp %h %h %b got %h %h %b", e.idx, e.value,
								e.sat, result_index, new_param, saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: sim/tb_adagrad_parameter_update.sv
// ----------------------------------------------------------------------------
// AdaGrad update testbench
// Directed corner words then random words under several register settings,
// with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_adagrad_parameter_update;
	import agu_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [0:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [IdxW-1:0]    element_index;
	logic signed [31:0] param_value;
	logic signed [31:0] gradient;
	logic               out_valid;
	logic               out_stall;
	logic [IdxW-1:0]    result_index;
	logic signed [31:0] new_param;
	logic               saturated;
	int                 fail_count;
	int                 pending;
	int                 cycles;
	bit                 quiet;
	bit                 hold_req;

	adagrad_parameter_update i_dut (.*);

	adagrad_parameter_update_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver side: random stall bursts, plus one long hold-off on request.
	initial begin
		int n;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1;
				for (int k = 0; k < 600; k++) @(negedge clk);
				hold_req = 0;
				out_stall <= 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				out_stall <= 1;
				repeat (n) @(negedge clk);
				out_stall <= 0;
			end
		end
	end

	task automatic write_reg(logic [0:0] r, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= r;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// Valid stays up after the accept; the next word or the drain takes it.
	task automatic send_word(logic [IdxW-1:0] idx, logic [31:0] p, logic [31:0] g);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid <= 1;
		element_index <= idx;
		param_value <= p;
		gradient <= g;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic random_phase(int n, int idx_span);
		logic [31:0] g;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 3))
				0: g = $urandom;
				1: g = $urandom_range(0, 65536 * 4) - 65536 * 2;
				2: g = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
				default: g = $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
			endcase
			send_word(IdxW'($urandom_range(0, idx_span)), $urandom, g);
		end
	endtask

	initial begin
		cycles = 0;
		quiet = 0;
		hold_req = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = RegLearningRate;
		cfg_data = 0;
		in_valid = 0;
		element_index = 0;
		param_value = 0;
		gradient = 0;
		repeat (6) @(negedge clk);
		arst_n = 1;

		// Defaults first: extremes of value and gradient.
		send_word(12'd0, 32'h7FFFFFFF, 32'h80000000);
		send_word(12'd4095, 32'h80000000, 32'h7FFFFFFF);
		send_word(12'd1, 32'd0, 32'd0);
		send_word(12'd1, 32'h00010000, 32'hFFFF0000);
		// The same element again and again drives its sum towards overflow.
		for (int k = 0; k < 6; k++) send_word(12'd7, 32'h80000000, 32'h80000000);
		drain();

		// A zero epsilon with an untouched element gives a zero denominator.
		write_reg(RegEpsilon, 32'd0);
		write_reg(RegLearningRate, 32'hFFFFFFFF);
		send_word(12'd100, 32'h12345678, 32'd0);
		send_word(12'd101, 32'h7FFFFFF0, 32'hFFFFFFFF);
		send_word(12'd102, 32'h80000010, 32'h00000001);
		send_word(12'd7, 32'd0, 32'h7FFFFFFF);
		drain();
		write_reg(RegEpsilon, 32'hFFFFFFFF);
		write_reg(RegLearningRate, 32'd0);
		send_word(12'd7, 32'h55555555, 32'h7FFFFFFF);
		send_word(12'd200, 32'hAAAAAAAA, 32'h80000001);
		drain();

		write_reg(RegLearningRate, 32'h00010000);
		write_reg(RegEpsilon, 32'd43);
		// Long hold-off while words keep coming.
		hold_req = 1;
		random_phase(250, 4095);
		drain();
		write_reg(RegLearningRate, $urandom);
		write_reg(RegEpsilon, $urandom_range(1, 1000));
		random_phase(250, 31);
		drain();
		write_reg(RegLearningRate, 32'hFFFFFFFF);
		write_reg(RegEpsilon, 32'hFFFFFFFF);
		random_phase(200, 4095);
		drain();
		write_reg(RegLearningRate, 32'd655);
		write_reg(RegEpsilon, 32'd1);
		quiet = 1;
		random_phase(230, 63);
		drain();

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// File: adagrad_parameter_update.f
+incdir+hdl
hdl/agu_pkg.sv
hdl/agu_divider.sv
hdl/adagrad_parameter_update.sv
hdl/agu_checker.sv
sim/adagrad_parameter_update_checker.sv
sim/tb_adagrad_parameter_update.sv
